// ===== rtl/vlc_pkg.sv =====
package vlc_pkg;

   // Default word and fraction widths of the Q-format fields
   localparam int WORD_BITS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;

   // Tolerance register
   localparam int          TOL_BITS  = 16;
   localparam logic [15:0] TOL_RESET = 16'd66;

endpackage

// ===== rtl/vlc_if.sv =====
interface vlc_req_if #(parameter int WORD_BITS = vlc_pkg::WORD_BITS_DEF);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] x_in;
   logic signed [WORD_BITS-1:0] y_in;
   logic        [WORD_BITS-2:0] max_length;

   modport source (output valid, x_in, y_in, max_length, input ready);
   modport sink   (input valid, x_in, y_in, max_length, output ready);
endinterface

interface vlc_rsp_if #(parameter int WORD_BITS = vlc_pkg::WORD_BITS_DEF);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] x_out;
   logic signed [WORD_BITS-1:0] y_out;
   logic                        clamped;

   modport source (output valid, x_out, y_out, clamped, input ready);
   modport sink   (input valid, x_out, y_out, clamped, output ready);
endinterface

interface vlc_csr_if;
   import vlc_pkg::*;
   logic                valid;
   logic                ready;
   logic [TOL_BITS-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/vector_length_clamp_top.sv =====
// Vector length clamp. Takes a 2D vector and a length limit in signed fixed point and
// returns the vector unchanged when its length is within the limit, or rescaled to the
// limit (square root and division truncated toward zero) with clamped set. A vector whose
// squared length is below tolerance squared is instead multiplied by the limit directly,
// saturating. One item is accepted every cycle while no finished item waits at the output.
// The pipe is three front stages (capture, multiply, sum and compare), one stage per root
// bit of the square root (WORD_BITS) and one per quotient bit of the divide (WORD_BITS-1),
// then the output register. The whole pipe holds while a finished item waits at the output.
// The tolerance register resets to 66 and is written through the csr channel.
module vector_length_clamp_top #(
   parameter int WORD_BITS = vlc_pkg::WORD_BITS_DEF,
   parameter int FRAC_BITS = vlc_pkg::FRAC_BITS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   vlc_req_if.sink       req_chan,
   vlc_rsp_if.source     rsp_chan,
   vlc_csr_if.sink       csr_chan
);
   import vlc_pkg::*;

   localparam int W   = WORD_BITS;
   localparam int D   = WORD_BITS - 1;
   localparam int M   = WORD_BITS;
   localparam int P   = 2 * WORD_BITS;
   localparam int PD  = 2 * WORD_BITS - 1;
   localparam int NST = M + D;

   typedef struct packed {
      logic [W-1:0]  xr;
      logic [W-1:0]  yr;
      logic          xn;
      logic          yn;
      logic [PD-1:0] pxd;
      logic [PD-1:0] pyd;
      logic          pass;
      logic          near;
      logic [W-1:0]  nx;
      logic [W-1:0]  ny;
      logic [P-1:0]  rem;
      logic [M-1:0]  root;
      logic [M-1:0]  rx;
      logic [M-1:0]  ry;
      logic [D-1:0]  qx;
      logic [D-1:0]  qy;
   } rec_type;

   logic en;

   // Tolerance register
   logic [TOL_BITS-1:0] tol_ff;
   assign csr_chan.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_chan.valid) begin
         tol_ff <= csr_chan.data;
      end
   end

   // Advance everything when the output is empty or being taken
   assign en             = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = en;

   // Stage 1: capture item
   logic                v1_ff;
   logic [W-1:0]        x1_ff, y1_ff;
   logic [D-1:0]        d1_ff;
   logic [TOL_BITS-1:0] t1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_chan.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         x1_ff <= req_chan.x_in;
         y1_ff <= req_chan.y_in;
         d1_ff <= req_chan.max_length;
         t1_ff <= tol_ff;
      end
   end

   // Stage 2: magnitudes and products
   logic                  v2_ff;
   logic [W-1:0]          x2_ff, y2_ff;
   logic                  xn2_ff, yn2_ff;
   logic [P-1:0]          pxx2_ff, pyy2_ff;
   logic [PD-1:0]         pxd2_ff, pyd2_ff;
   logic [2*D-1:0]        dd2_ff;
   logic [2*TOL_BITS-1:0] tt2_ff;
   logic [W-1:0]          xm_in, ym_in;
   assign xm_in = x1_ff[W-1] ? (~x1_ff + W'(1)) : x1_ff;
   assign ym_in = y1_ff[W-1] ? (~y1_ff + W'(1)) : y1_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         x2_ff   <= x1_ff;
         y2_ff   <= y1_ff;
         xn2_ff  <= x1_ff[W-1];
         yn2_ff  <= y1_ff[W-1];
         pxx2_ff <= P'(xm_in) * P'(xm_in);
         pyy2_ff <= P'(ym_in) * P'(ym_in);
         pxd2_ff <= PD'(xm_in) * PD'(d1_ff);
         pyd2_ff <= PD'(ym_in) * PD'(d1_ff);
         dd2_ff  <= (2*D)'(d1_ff) * (2*D)'(d1_ff);
         tt2_ff  <= (2*TOL_BITS)'(t1_ff) * (2*TOL_BITS)'(t1_ff);
      end
   end

   // Stage 3: squared length, compares and the saturated near-zero result
   localparam int SH = PD - FRAC_BITS;
   logic [P-1:0]  msq_in;
   logic [SH-1:0] sx_in, sy_in;
   logic [W-1:0]  nx_in, ny_in;
   logic [W-1:0]  lim_pos, lim_neg;
   assign msq_in  = pxx2_ff + pyy2_ff;
   assign sx_in   = SH'(pxd2_ff >> FRAC_BITS);
   assign sy_in   = SH'(pyd2_ff >> FRAC_BITS);
   assign lim_pos = {1'b0, {(W-1){1'b1}}};
   assign lim_neg = {1'b1, {(W-1){1'b0}}};

   always_comb begin
      logic [W-1:0] mx, my;
      mx = xn2_ff ? ((sx_in > SH'(lim_neg)) ? lim_neg : W'(sx_in))
                  : ((sx_in > SH'(lim_pos)) ? lim_pos : W'(sx_in));
      my = yn2_ff ? ((sy_in > SH'(lim_neg)) ? lim_neg : W'(sy_in))
                  : ((sy_in > SH'(lim_pos)) ? lim_pos : W'(sy_in));
      nx_in = xn2_ff ? (~mx + W'(1)) : mx;
      ny_in = yn2_ff ? (~my + W'(1)) : my;
   end

   rec_type mid_ff [NST+1];
   logic    mid_v_ff [NST+1];
   rec_type step_in [NST];

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_v_ff[0] <= 1'b0;
      end else if (en) begin
         mid_v_ff[0] <= v2_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         mid_ff[0].xr   <= x2_ff;
         mid_ff[0].yr   <= y2_ff;
         mid_ff[0].xn   <= xn2_ff;
         mid_ff[0].yn   <= yn2_ff;
         mid_ff[0].pxd  <= pxd2_ff;
         mid_ff[0].pyd  <= pyd2_ff;
         mid_ff[0].pass <= msq_in <= P'(dd2_ff);
         mid_ff[0].near <= msq_in < P'(tt2_ff);
         mid_ff[0].nx   <= nx_in;
         mid_ff[0].ny   <= ny_in;
         mid_ff[0].rem  <= msq_in;
         mid_ff[0].root <= '0;
         mid_ff[0].rx   <= pxd2_ff[PD-1:D];
         mid_ff[0].ry   <= pyd2_ff[PD-1:D];
         mid_ff[0].qx   <= '0;
         mid_ff[0].qy   <= '0;
      end
   end

   // Square root one bit per stage, then divide one quotient bit per stage
   for (genvar k = 0; k < NST; k++) begin : g_step
      if (k < M) begin : g_root
         localparam int B = M - 1 - k;
         always_comb begin
            logic [P:0] t;
            step_in[k] = mid_ff[k];
            t = ((P+1)'(mid_ff[k].root) << (B + 1)) | ((P+1)'(1) << (2 * B));
            if ({1'b0, mid_ff[k].rem} >= t) begin
               step_in[k].rem  = mid_ff[k].rem - t[P-1:0];
               step_in[k].root = mid_ff[k].root | (M'(1) << B);
            end
         end
      end else begin : g_div
         localparam int J = D - 1 - (k - M);
         always_comb begin
            logic [M:0] rx, ry;
            step_in[k] = mid_ff[k];
            rx = {mid_ff[k].rx, mid_ff[k].pxd[J]};
            ry = {mid_ff[k].ry, mid_ff[k].pyd[J]};
            if (rx >= {1'b0, mid_ff[k].root}) begin
               rx = rx - {1'b0, mid_ff[k].root};
               step_in[k].qx = mid_ff[k].qx | (D'(1) << J);
            end
            if (ry >= {1'b0, mid_ff[k].root}) begin
               ry = ry - {1'b0, mid_ff[k].root};
               step_in[k].qy = mid_ff[k].qy | (D'(1) << J);
            end
            step_in[k].rx = rx[M-1:0];
            step_in[k].ry = ry[M-1:0];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            mid_v_ff[k+1] <= 1'b0;
         end else if (en) begin
            mid_v_ff[k+1] <= mid_v_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            mid_ff[k+1] <= step_in[k];
         end
      end
   end

   // Output register: pick pass-through, near-zero or scaled result
   logic         out_v_ff;
   logic [W-1:0] out_x_ff, out_y_ff;
   logic         out_c_ff;
   logic [W-1:0] ox_in, oy_in;
   rec_type      fin;
   assign fin = mid_ff[NST];

   always_comb begin
      if (fin.pass) begin
         ox_in = fin.xr;
         oy_in = fin.yr;
      end else if (fin.near) begin
         ox_in = fin.nx;
         oy_in = fin.ny;
      end else begin
         ox_in = fin.xn ? (~W'(fin.qx) + W'(1)) : W'(fin.qx);
         oy_in = fin.yn ? (~W'(fin.qy) + W'(1)) : W'(fin.qy);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (en) begin
         out_v_ff <= mid_v_ff[NST];
      end
   end
   always_ff @(posedge clock) begin
      if (en) begin
         out_x_ff <= ox_in;
         out_y_ff <= oy_in;
         out_c_ff <= !fin.pass;
      end
   end

   assign rsp_chan.valid   = out_v_ff;
   assign rsp_chan.x_out   = out_x_ff;
   assign rsp_chan.y_out   = out_y_ff;
   assign rsp_chan.clamped = out_c_ff;

endmodule

// ===== dv/vector_length_clamp_top_tb.sv =====
module vector_length_clamp_top_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vlc_pkg::*;

   localparam int WB = WORD_BITS_DEF;
   localparam int FB = FRAC_BITS_DEF;
   localparam int LATENCY = 2 * WB + 3;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic signed [WB-1:0] x;
      logic signed [WB-1:0] y;
      logic                 clamped;
   } clamp_result_t;

   typedef struct {
      logic signed [WB-1:0] x;
      logic signed [WB-1:0] y;
      logic [WB-2:0]        d;
      bit                   has_gold;
      clamp_result_t        gold;
   } vec_row_t;

   logic clock;
   logic reset;

   vlc_req_if #(.WORD_BITS(WB)) req_chan ();
   vlc_rsp_if #(.WORD_BITS(WB)) rsp_chan ();
   vlc_csr_if                   csr_chan ();

   vector_length_clamp_top #(.WORD_BITS(WB), .FRAC_BITS(FB)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   logic [15:0]   tol_shadow;
   clamp_result_t clamp_expect_q[$];
   vec_row_t      dir_rows[$];
   int            error_count;
   int            idle_cycles;
   int            hold_off_cycles;
   bit            stim_done;

   // Clock generation
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Integer square root, floor
   function automatic logic [63:0] isqrt(logic [127:0] n);
      logic [63:0]  res;
      logic [63:0]  cand;
      res = '0;
      for (int b = 63; b >= 0; b--) begin
         cand = res | (64'd1 << b);
         if ({64'd0, cand} * {64'd0, cand} <= n) res = cand;
      end
      return res;
   endfunction

   // Compute the clamped vector for one item
   function automatic clamp_result_t clamp_vector(logic signed [WB-1:0] x,
                                                  logic signed [WB-1:0] y,
                                                  logic [WB-2:0] d,
                                                  logic [15:0] tol);
      clamp_result_t r;
      logic [127:0]  xm, ym, dw, msq, mag, px, py;
      logic [127:0]  tsq;
      bit            xn, yn;
      xn  = x[WB-1];
      yn  = y[WB-1];
      xm  = xn ? 128'(-{1'b0, x} & {1'b0, {WB{1'b1}}}) : 128'(unsigned'(x));
      ym  = yn ? 128'(-{1'b0, y} & {1'b0, {WB{1'b1}}}) : 128'(unsigned'(y));
      xm  = xm & ((128'd1 << WB) - 1);
      ym  = ym & ((128'd1 << WB) - 1);
      dw  = 128'(d);
      msq = xm * xm + ym * ym;
      tsq = 128'(tol) * 128'(tol);
      if (msq <= dw * dw) begin
         r.x = x;
         r.y = y;
         r.clamped = 1'b0;
         return r;
      end
      if (tsq > msq) begin
         // near zero: scale by the limit directly, saturate
         px = (xm * dw) >> FB;
         py = (ym * dw) >> FB;
         if (px > (xn ? (128'd1 << (WB-1)) : (128'd1 << (WB-1)) - 1))
            px = xn ? (128'd1 << (WB-1)) : (128'd1 << (WB-1)) - 1;
         if (py > (yn ? (128'd1 << (WB-1)) : (128'd1 << (WB-1)) - 1))
            py = yn ? (128'd1 << (WB-1)) : (128'd1 << (WB-1)) - 1;
      end else begin
         mag = 128'(isqrt(msq));
         px  = (xm * dw) / mag;
         py  = (ym * dw) / mag;
      end
      r.x = xn ? WB'(-px) : WB'(px);
      r.y = yn ? WB'(-py) : WB'(py);
      r.clamped = 1'b1;
      return r;
   endfunction

   // Report one mismatch and count it
   task automatic report_mismatch(string what, logic [WB-1:0] got, logic [WB-1:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Send one item after a random gap; valid stays up until the caller drops it
   task automatic send_vector(logic signed [WB-1:0] x, logic signed [WB-1:0] y,
                              logic [WB-2:0] d, bit has_gold, clamp_result_t gold);
      int gap;
      clamp_result_t pred;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.x_in       <= x;
      req_chan.y_in       <= y;
      req_chan.max_length <= d;
      do @(posedge clock); while (!req_chan.ready);
      pred = clamp_vector(x, y, d, tol_shadow);
      if (has_gold) begin
         if (pred.x !== gold.x) report_mismatch("directed x_out", pred.x, gold.x);
         if (pred.y !== gold.y) report_mismatch("directed y_out", pred.y, gold.y);
         if (pred.clamped !== gold.clamped)
            report_mismatch("directed clamped", WB'(pred.clamped), WB'(gold.clamped));
      end
      clamp_expect_q.push_back(pred);
   endtask

   // Write the tolerance register while idle
   task automatic write_tolerance(logic [15:0] val);
      wait (clamp_expect_q.size() == 0);
      repeat (LATENCY + 4) @(posedge clock);
      csr_chan.valid <= 1'b1;
      csr_chan.data  <= val;
      do @(posedge clock); while (!csr_chan.ready);
      csr_chan.valid <= 1'b0;
      tol_shadow = val;
   endtask

   function automatic logic signed [WB-1:0] rand_word();
      case ($urandom_range(0, 5))
         0: return WB'($urandom_range(0, 255)) - 128;
         1: return {$urandom()} >>> $urandom_range(0, 31);
         2: return -($urandom() >> $urandom_range(8, 31));
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [WB-2:0] rand_len();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return (WB-1)'($urandom_range(0, 1023));
         2: return (WB-1)'(($urandom() >> 1) >> $urandom_range(0, 30));
         default: return (WB-1)'($urandom() >> 1);
      endcase
   endfunction

   // Stimulus
   initial begin
      clamp_result_t g;
      vec_row_t      row;
      reset          = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.x_in  = '0;
      req_chan.y_in  = '0;
      req_chan.max_length = '0;
      csr_chan.valid = 1'b0;
      csr_chan.data  = '0;
      tol_shadow     = TOL_RESET;
      error_count    = 0;
      stim_done      = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed rows: zero, extremes, near zero, zero limit
      dir_rows = '{
         '{32'sd0, 32'sd0, 31'd0, 1'b1, '{32'sd0, 32'sd0, 1'b0}},
         '{32'sd65536, 32'sd0, 31'd65536, 1'b1, '{32'sd65536, 32'sd0, 1'b0}},
         '{32'sd131072, 32'sd0, 31'd65536, 1'b1, '{32'sd65536, 32'sd0, 1'b1}},
         '{-32'sd131072, 32'sd0, 31'd65536, 1'b1, '{-32'sd65536, 32'sd0, 1'b1}},
         '{32'sd3, 32'sd0, 31'd0, 1'b1, '{32'sd0, 32'sd0, 1'b1}},
         '{32'sd5, -32'sd7, 31'h7FFFFFFF, 1'b1, '{32'sd5, -32'sd7, 1'b0}},
         '{32'sd10, 32'sd10, 31'd1, 1'b0, '{0, 0, 0}},
         '{32'h80000000, 32'h80000000, 31'd0, 1'b0, '{0, 0, 0}},
         '{32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 1'b0, '{0, 0, 0}},
         '{32'h80000000, 32'h7FFFFFFF, 31'h7FFFFFFF, 1'b0, '{0, 0, 0}},
         '{32'h80000000, 32'sd0, 31'h7FFFFFFF, 1'b0, '{0, 0, 0}},
         '{32'h7FFFFFFF, -32'sd1, 31'd12345, 1'b0, '{0, 0, 0}},
         '{-32'sd1, -32'sd1, 31'd0, 1'b0, '{0, 0, 0}},
         '{32'sd30, -32'sd40, 31'd65536, 1'b0, '{0, 0, 0}},
         '{32'sd300000, 32'sd400000, 31'd65536, 1'b0, '{0, 0, 0}}
      };
      foreach (dir_rows[i]) begin
         row = dir_rows[i];
         send_vector(row.x, row.y, row.d, row.has_gold, row.gold);
      end
      req_chan.valid <= 1'b0;

      // Random phases over several tolerance settings, extremes included
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_tolerance(16'd0);
            1: write_tolerance(16'hFFFF);
            2: write_tolerance(16'd1000);
            3: write_tolerance(16'($urandom()));
            default: write_tolerance(TOL_RESET);
         endcase
         for (int n = 0; n < 127; n++)
            send_vector(rand_word(), rand_word(), rand_len(), 1'b0, g);
         req_chan.valid <= 1'b0;
         if (ph == 2) wait (clamp_expect_q.size() == 0);
      end
      stim_done = 1'b1;
   end

   // Result side: random stalls plus one long hold-off
   initial begin
      int stall;
      rsp_chan.ready  = 1'b0;
      hold_off_cycles = 0;
      @(negedge reset);
      forever begin
         if (hold_off_cycles == 0 && clamp_expect_q.size() > 4) begin
            rsp_chan.ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_off_cycles = 300;
         end
         stall = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 15);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      clamp_result_t want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (clamp_expect_q.size() == 0) begin
            report_mismatch("unexpected result x_out", rsp_chan.x_out, '0);
         end else begin
            want = clamp_expect_q.pop_front();
            if (rsp_chan.x_out !== want.x) report_mismatch("x_out", rsp_chan.x_out, want.x);
            if (rsp_chan.y_out !== want.y) report_mismatch("y_out", rsp_chan.y_out, want.y);
            if (rsp_chan.clamped !== want.clamped)
               report_mismatch("clamped", WB'(rsp_chan.clamped), WB'(want.clamped));
         end
      end
   end

   // Watchdog on cycles with no accepted item
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   // End of run
   initial begin
      idle_cycles = 0;
      fork
         begin
            wait (stim_done && clamp_expect_q.size() == 0);
            repeat (LATENCY + 10) @(posedge clock);
         end
         wait (idle_cycles >= WATCHDOG_LIMIT);
      join_any
      if (error_count == 0 && clamp_expect_q.size() == 0 && idle_cycles < WATCHDOG_LIMIT) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
